/* hdl/psr_pkg.sv */
// ============================================================================
// psr_pkg - shared constants, types and coefficient table
// Rate constants, derived sizes, word and state types, and the windowed-sinc
// coefficient table built at elaboration.
// ============================================================================
package psr_pkg;

    // ---- rate and kernel constants --------------------------------------
    localparam int SOURCE_STEP    = 2;
    localparam int TARGET_STEP    = 3;
    localparam int ZERO_CROSSINGS = 6;
    localparam int COEF_FRAC_BITS = 16;
    localparam int MAX_RESULTS    = 24;
    localparam int SAMPLE_W       = 16;

    // gcd by repeated subtraction, both arguments at least 1
    function automatic int gcd_of(input int a, input int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

    localparam int GCD_ST      = gcd_of(SOURCE_STEP, TARGET_STEP);
    localparam int RED_S       = SOURCE_STEP / GCD_ST;
    localparam int RED_T       = TARGET_STEP / GCD_ST;
    localparam int MIN_STEP    = (SOURCE_STEP < TARGET_STEP) ? SOURCE_STEP : TARGET_STEP;
    localparam int HALF_WIDTH  = (ZERO_CROSSINGS * SOURCE_STEP * 100 + MIN_STEP * 99 - 1)
                                 / (MIN_STEP * 99);
    localparam int TAPS        = 2 * HALF_WIDTH + RED_S;
    localparam int ROM_DEPTH   = RED_T * TAPS;
    localparam int COEF_W      = COEF_FRAC_BITS + 2;
    localparam int TAP_AW      = $clog2(TAPS);
    localparam int ROM_AW      = $clog2(ROM_DEPTH);
    localparam int PH_W        = (RED_T > 1) ? $clog2(RED_T) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int STEP_MAX    = (RED_S > RED_T) ? RED_S : RED_T;
    localparam int WIDE_W      = 32 + $clog2(STEP_MAX + 1) + 1;
    localparam int ACC_W       = SAMPLE_W + COEF_W + TAP_AW;
    localparam int NEED_INIT   = HALF_WIDTH + RED_S;
    localparam bit EQUAL_RATES = (SOURCE_STEP == TARGET_STEP);

    // ---- input queue ------------------------------------------------------
    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = QA_W + 1;

    // ---- kernel build constants -------------------------------------------
    localparam int K_MN  = (RED_S < RED_T) ? RED_S : RED_T;
    localparam int K_DEN = RED_S * RED_T * 100;
    localparam int K_LIM = ZERO_CROSSINGS * K_DEN;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // ---- types ------------------------------------------------------------
    typedef logic [ROM_DEPTH-1:0][COEF_W-1:0] t_rom;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_LAST,
        CMD_PASS,
        CMD_PASS_LAST
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                   kind;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_ROUND
    } t_back_state;

    // unsigned shift-and-subtract quotient, elaboration only; d nonzero
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin of a phase given in 2^-32 turns, signed Q30, Taylor to x^17
    function automatic longint sin_q30(input logic [63:0] ph);
        logic [63:0] fr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [1:0]  quad;
        longint      s;
        quad = ph[31:30];
        fr   = ph & (ONE_Q30 - 64'd1);
        if (quad[0]) begin
            fr = ONE_Q30 - fr;
        end
        x    = (fr * PI_Q30) >> 31;
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   s = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  s = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  s = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  s = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; s = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; s = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; s = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; s = s + longint'(term);
        if (quad[1]) begin
            s = -s;
        end
        return s;
    endfunction

    // one kernel coefficient, elaboration only
    function automatic longint coef_entry(input int p, input int j);
        longint      num;
        longint      sn;
        logic [63:0] an;
        logic [63:0] pit;
        logic [63:0] sinc;
        logic [63:0] w;
        logic [63:0] w2;
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] ph;
        logic        neg;
        neg = 1'b0;
        num = (longint'(j) - longint'(HALF_WIDTH)) * longint'(RED_T)
              - longint'(p) * longint'(RED_S);
        num = num * longint'(K_MN * 99);
        an  = (num < 0) ? 64'(-num) : 64'(num);
        if (an > 64'(K_LIM)) begin
            an = 64'(K_LIM);
        end
        if (an == 64'd0) begin
            sinc = ONE_Q30;
        end else begin
            pit = (PI_Q30 * an) / 64'(K_DEN);
            r   = an % 64'(2 * K_DEN);
            ph  = (r << 32) / 64'(2 * K_DEN);
            sn  = sin_q30(ph);
            if (sn < 0) begin
                neg = 1'b1;
                sn  = -sn;
            end
            sinc = (pit != 64'd0) ? udiv64(64'(sn) << 30, pit) : 64'd0;
        end
        ph     = ((64'(K_LIM) - an) << 32) / 64'(4 * K_LIM);
        sn     = sin_q30(ph);
        w      = (sn < 0) ? 64'd0 : 64'(sn);
        w2     = (w * w) >> 30;
        mag    = (sinc * w2) >> 30;
        scaled = (mag * 64'(K_MN * 99) + 64'(50 * RED_S)) / 64'(100 * RED_S);
        q      = (scaled + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        rom = '0;
        for (int p = 0; p < RED_T; p++) begin
            for (int j = 0; j < TAPS; j++) begin
                rom[p * TAPS + j] = COEF_W'(coef_entry(p, j));
            end
        end
        return rom;
    endfunction

    // phase-major: entry phase*TAPS + tap
    localparam t_rom COEF_ROM = build_rom();

endpackage

/* hdl/psr_if.sv */
// ============================================================================
// psr_if - stream channels
// Valid/ready channels for input samples and resampled output samples.
// ============================================================================
interface psr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [psr_pkg::SAMPLE_W-1:0]    sample_in;
    logic                                   is_final;

    modport source (output valid, output sample_in, output is_final, input ready);
    modport sink   (input valid, input sample_in, input is_final, output ready);
endinterface

interface psr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [psr_pkg::SAMPLE_W-1:0]    sample_out;
    logic                                   end_of_stream;

    modport source (output valid, output sample_out, output end_of_stream, input ready);
    modport sink   (input valid, input sample_out, input end_of_stream, output ready);
endinterface

/* hdl/polyphase_sinc_resampler_core.sv */
// ============================================================================
// polyphase_sinc_resampler_core - rational polyphase resampler
// Windowed-sinc polyphase filter, SOURCE_STEP:TARGET_STEP rate change, with
// end-of-stream flush and rounding/saturation to Q1.15.
// ============================================================================
// Path: a word that completes a block goes through the queue, a check, a multiply-accumulate
//   per tap, rounding and the output register before its first output shows.
// Throughput: one multiply-accumulate per cycle through a single multiplier; no new word
//   is taken from the queue until the engine is through with every output of the last one.
// Equal rates: words pass through at one per cycle while the output is ready, via the queue and the output register.
// Reset (i_rst_n low, synchronous): history zeroed, counters cleared, queue
//   and output register emptied; the coefficient table is constant logic.
module polyphase_sinc_resampler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psr_in_if.sink      i_in,
    psr_out_if.source   o_out
);
    import psr_pkg::*;

    // queue head between the intake and the filter engine
    t_cmd  w_head;
    logic  w_head_valid;
    logic  w_head_pop;

    // Intake: two-word queue, so input keeps flowing while the engine works
    // through the outputs of the previous word.
    psr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_head_pop   (w_head_pop)
    );

    // Engine: shifts the word into the tap history, then emits every output
    // whose block is complete, up to MAX_RESULTS per word (padding zeros on the last
    // word), one tap per cycle through a single multiplier. Each result is held
    // until the next decision so the last of a flush can carry end_of_stream.
    psr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_head_pop   (w_head_pop),
        .o_out        (o_out)
    );

endmodule

/* hdl/psr_front.sv */
// ============================================================================
// psr_front - input side
// Takes input words, tags them by kind and holds them in a short queue.
// ============================================================================
module psr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psr_in_if.sink         i_in,
    output psr_pkg::t_cmd  o_head,
    output logic           o_head_valid,
    input  logic           i_head_pop
);
    import psr_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QC_W-1:0]   r_count;

    logic              w_push;
    logic              w_pop;
    t_cmd              w_cmd;

    // tag the word
    always_comb begin
        w_cmd.sample = i_in.sample_in;
        if (EQUAL_RATES) begin
            w_cmd.kind = i_in.is_final ? CMD_PASS_LAST : CMD_PASS;
        end else begin
            w_cmd.kind = i_in.is_final ? CMD_LAST : CMD_SAMPLE;
        end
    end

    assign i_in.ready   = (r_count != QC_W'(QUEUE_DEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign w_pop        = i_head_pop && (r_count != '0);
    assign o_head       = r_slot[r_rd];
    assign o_head_valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/psr_back.sv */
// ============================================================================
// psr_back - filter engine
// Tap history, emission sequencer, serial multiply-accumulate over the taps,
// rounding and saturation, and the output register.
// ============================================================================
module psr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psr_pkg::t_cmd  i_head,
    input  logic           i_head_valid,
    output logic           o_head_pop,
    psr_out_if.source      o_out
);
    import psr_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sd32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32'sd32768);

    t_back_state                  r_state;
    t_back_state                  n_state;

    logic signed [SAMPLE_W-1:0]   r_taps [TAPS];
    logic [31:0]                  r_seen;
    logic [31:0]                  r_emit;
    logic [WIDE_W-1:0]            r_filled;
    logic [WIDE_W-1:0]            r_need;
    logic [WIDE_W-1:0]            r_tn;
    logic [PH_W-1:0]              r_phase;
    logic [ROM_AW-1:0]            r_base;
    logic                         r_fin;
    logic [CNT_W-1:0]             r_cnt;
    logic [TAP_AW-1:0]            r_tap_idx;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [SAMPLE_W-1:0]   r_pend_val;
    logic                         r_pend_valid;
    logic                         r_out_valid;
    logic signed [SAMPLE_W-1:0]   r_out_sample;
    logic                         r_out_eos;

    logic [31:0]                  w_seen_inc;
    logic [WIDE_W-1:0]            w_ms;
    logic                         w_enough;
    logic                         w_stop;
    logic                         w_pad;
    logic                         w_slot_free;
    logic                         w_release;
    logic                         w_go;
    logic                         w_is_pass;
    logic                         w_head_last;
    logic signed [SAMPLE_W-1:0]   w_shift_val;
    logic signed [COEF_W-1:0]     w_coef;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [ACC_W-1:0]      w_rsum;
    logic signed [ACC_W-1:0]      w_shr;
    logic signed [SAMPLE_W-1:0]   w_sat;

    // strobes
    logic s_pop;
    logic s_take;
    logic s_pass;
    logic s_release;
    logic s_clear;
    logic s_pad;
    logic s_start;
    logic s_mac;
    logic s_round;

    // ---- classification of the queue head ---------------------------------
    always_comb begin
        unique case (i_head.kind)
            CMD_SAMPLE: begin
                w_is_pass   = 1'b0;
                w_head_last = 1'b0;
            end
            CMD_LAST: begin
                w_is_pass   = 1'b0;
                w_head_last = 1'b1;
            end
            CMD_PASS: begin
                w_is_pass   = 1'b1;
                w_head_last = 1'b0;
            end
            CMD_PASS_LAST: begin
                w_is_pass   = 1'b1;
                w_head_last = 1'b1;
            end
            default: begin
                w_is_pass   = 1'b0;
                w_head_last = 1'b0;
            end
        endcase
    end

    // ---- emission decision --------------------------------------------------
    // end of flush: ceil(T*N/S) <= emitted  <=>  T*N <= S*emitted
    assign w_seen_inc  = r_seen + 32'd1;
    assign w_ms        = WIDE_W'(r_emit) * WIDE_W'(RED_S);
    assign w_enough    = (r_filled >= r_need);
    assign w_stop      = (r_cnt == CNT_W'(MAX_RESULTS))
                         || (r_fin && (w_ms >= r_tn))
                         || (!w_enough && !r_fin);
    assign w_pad       = !w_stop && !w_enough;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_release   = r_pend_valid && !w_pad;
    assign w_go        = !w_release || w_slot_free;

    // ---- datapath -----------------------------------------------------------
    assign w_shift_val = s_take ? i_head.sample : '0;
    assign w_coef      = COEF_ROM[r_base + ROM_AW'(r_tap_idx)];
    assign w_prod      = r_taps[r_tap_idx] * w_coef;
    assign w_rsum      = r_acc + ROUND_HALF;
    assign w_shr       = w_rsum >>> COEF_FRAC_BITS;

    always_comb begin
        if (w_shr > SAT_HI) begin
            w_sat = SAMPLE_W'(SAT_HI);
        end else if (w_shr < SAT_LO) begin
            w_sat = SAMPLE_W'(SAT_LO);
        end else begin
            w_sat = SAMPLE_W'(w_shr);
        end
    end

    // ---- next state -----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid && !w_is_pass) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_go) begin
                    if (w_stop) begin
                        n_state = ST_IDLE;
                    end else if (!w_pad) begin
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (r_tap_idx == TAP_AW'(TAPS - 1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- strobes ----------------------------------------------------------------
    always_comb begin
        s_pop     = 1'b0;
        s_release = 1'b0;
        s_clear   = 1'b0;
        s_pad     = 1'b0;
        s_start   = 1'b0;
        s_mac     = 1'b0;
        s_round   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_pop = i_head_valid && (!w_is_pass || w_slot_free);
            end
            ST_CHECK: begin
                s_release = w_release && w_slot_free;
                s_clear   = w_go && w_stop && r_fin;
                s_pad     = w_pad;
                s_start   = w_go && !w_stop && !w_pad;
            end
            ST_MAC: begin
                s_mac = 1'b1;
            end
            ST_ROUND: begin
                s_round = 1'b1;
            end
            default: begin
                s_pop = 1'b0;
            end
        endcase
    end

    assign s_take     = s_pop && !w_is_pass;
    assign s_pass     = s_pop && w_is_pass;
    assign o_head_pop = s_pop;

    // ---- control registers ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seen       <= '0;
            r_emit       <= '0;
            r_filled     <= '0;
            r_need       <= WIDE_W'(NEED_INIT);
            r_phase      <= '0;
            r_base       <= '0;
            r_fin        <= 1'b0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_taps[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (s_clear) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_taps[i] <= '0;
                end
            end else if (s_take || s_pad) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_taps[i] <= r_taps[i + 1];
                end
                r_taps[TAPS - 1] <= w_shift_val;
            end

            if (s_take) begin
                r_seen   <= w_seen_inc;
                r_filled <= WIDE_W'(w_seen_inc);
                r_fin    <= w_head_last;
                r_cnt    <= '0;
            end else if (s_clear) begin
                r_seen   <= '0;
                r_filled <= '0;
            end else if (s_pad) begin
                r_filled <= r_filled + 1'b1;
            end

            // output index bookkeeping: phase, block need, table base
            if (s_clear) begin
                r_emit  <= '0;
                r_phase <= '0;
                r_base  <= '0;
                r_need  <= WIDE_W'(NEED_INIT);
            end else if (s_round) begin
                r_cnt  <= r_cnt + 1'b1;
                r_emit <= r_emit + 32'd1;
                if (r_emit == '1) begin
                    r_phase <= '0;
                    r_base  <= '0;
                    r_need  <= WIDE_W'(NEED_INIT);
                end else if (r_phase == PH_W'(RED_T - 1)) begin
                    r_phase <= '0;
                    r_base  <= '0;
                    r_need  <= r_need + WIDE_W'(RED_S);
                end else begin
                    r_phase <= r_phase + 1'b1;
                    r_base  <= r_base + ROM_AW'(TAPS);
                end
            end

            if (s_round) begin
                r_pend_valid <= 1'b1;
            end else if (s_release) begin
                r_pend_valid <= 1'b0;
            end

            if (s_release || s_pass) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_tn <= WIDE_W'(w_seen_inc) * WIDE_W'(RED_T);
        end
        if (s_start) begin
            r_acc     <= '0;
            r_tap_idx <= '0;
        end else if (s_mac) begin
            r_acc     <= r_acc + ACC_W'(w_prod);
            r_tap_idx <= r_tap_idx + 1'b1;
        end
        if (s_round) begin
            r_pend_val <= w_sat;
        end
        if (s_pass) begin
            r_out_sample <= i_head.sample;
            r_out_eos    <= w_head_last;
        end else if (s_release) begin
            r_out_sample <= r_pend_val;
            r_out_eos    <= r_fin && w_stop;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample_out    = r_out_sample;
    assign o_out.end_of_stream = r_out_eos;

    // ---- assertions -----------------------------------------------------------
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("per-word output count beyond cap");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_W'(RED_T - 1))
        else $error("phase out of range");

    a_no_pend_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> !r_pend_valid)
        else $error("dot product started with an unreleased result");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_clear |=> (r_seen == '0 && r_emit == '0 && !r_pend_valid
                     && r_state == ST_IDLE))
        else $error("stream end did not rearm");

endmodule

/* verif/tb.sv */
// ============================================================================
// tb - polyphase sinc resampler core testbench
// Drives mono sample streams through the core and compares every resampled
// word against an in-bench integer model of the kernel and the flush rules.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    import psr_pkg::*;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eos;
    } t_resampled_word;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    localparam int   RS          = RED_S;
    localparam int   RT          = RED_T;
    localparam int   HW          = HALF_WIDTH;
    localparam int   ZC          = ZERO_CROSSINGS;
    localparam int   CFB         = COEF_FRAC_BITS;
    localparam int   SAMPLE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
    localparam int   SAMPLE_MIN  = -(2 ** (SAMPLE_W - 1));
    localparam t_u64 PI_FIX      = 64'd3373259426;
    localparam t_u64 UNIT_Q30    = 64'd1 << 30;
    localparam int   HOLD_CYCLES = 400;
    localparam int   QUIET_LIMIT = 5000;
    localparam int   TAIL_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psr_in_if  in_ch ();
    psr_out_if out_ch ();

    polyphase_sinc_resampler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- model state -----------------------------------------------------
    int                         kernel_taps [RT * TAPS];
    logic signed [SAMPLE_W-1:0] tap_line [TAPS];
    logic [31:0]                samples_seen;
    logic [31:0]                outputs_emitted;
    t_resampled_word            expected_words [$];
    t_resampled_word            oldest_word;

    int       n_errors     = 0;
    int       burst_left   = 0;
    int       quiet_cycles = 0;
    bit       hold_request = 1'b0;
    int       held;
    int       rx_left      = 0;
    int       rx_tick      = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    // ---- kernel build ------------------------------------------------------
    // sin(2*pi*num/den), Q30, Taylor to x^17 with truncating steps
    function automatic longint sine_of_turns(t_u64 num, t_u64 den);
        t_u64   rem;
        t_u64   ph;
        t_u64   fr;
        t_u64   x;
        t_u64   x2;
        t_u64   term;
        longint acc;
        if (den == 0) begin
            return 0;
        end
        rem = num % den;
        ph  = (rem << 32) / den;
        fr  = ph & (UNIT_Q30 - 1);
        if (ph[30]) begin
            fr = UNIT_Q30 - fr;
        end
        x    = (fr * PI_FIX) >> 31;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / t_u64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return ph[31] ? -acc : acc;
    endfunction

    // cos^2-windowed sinc, scaled by 0.99*min/S, rounded to CFB fraction bits
    function automatic int kernel_coef(int ph, int tap);
        longint num;
        longint sn;
        t_u64   mn;
        t_u64   den;
        t_u64   lim;
        t_u64   an;
        t_u64   pit;
        t_u64   sinc;
        t_u64   w;
        t_u64   w2;
        t_u64   mag;
        t_u64   scaled;
        t_u64   q;
        bit     neg;
        mn  = (RS < RT) ? RS : RT;
        den = RS * RT * 100;
        lim = ZC * den;
        neg = 1'b0;
        num = (longint'(tap) - HW) * RT - longint'(ph) * RS;
        num = num * longint'(mn * 99);
        an  = (num < 0) ? -num : num;
        if (an > lim) begin
            an = lim;
        end
        if (an == 0) begin
            sinc = UNIT_Q30;    // center tap: exactly one
        end else begin
            pit = (PI_FIX * an) / den;
            sn  = sine_of_turns(an, 2 * den);
            if (sn < 0) begin
                neg = 1'b1;
                sn  = -sn;
            end
            sinc = (pit != 0) ? ((t_u64'(sn) << 30) / pit) : t_u64'(0);
        end
        sn     = sine_of_turns(lim - an, 4 * lim);
        w      = (sn < 0) ? t_u64'(0) : t_u64'(sn);
        w2     = (w * w) >> 30;
        mag    = (sinc * w2) >> 30;
        scaled = (mag * mn * 99 + 50 * RS) / (100 * RS);
        q      = (scaled + (t_u64'(1) << (29 - CFB))) >> (30 - CFB);
        return neg ? -int'(q) : int'(q);
    endfunction

    // ---- stream model ------------------------------------------------------
    function automatic void clear_stream_state();
        for (int j = 0; j < TAPS; j++) begin
            tap_line[j] = '0;
        end
        samples_seen    = '0;
        outputs_emitted = '0;
    endfunction

    function automatic void shift_tap(logic signed [SAMPLE_W-1:0] s);
        for (int j = 0; j < TAPS - 1; j++) begin
            tap_line[j] = tap_line[j + 1];
        end
        tap_line[TAPS - 1] = s;
    endfunction

    function automatic void add_expected(t_resampled_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // dot product, floor after +half, then clamp to Q1.15
    function automatic logic signed [SAMPLE_W-1:0] phase_dot(int ph);
        longint acc;
        acc = 0;
        for (int j = 0; j < TAPS; j++) begin
            acc = acc + longint'(tap_line[j]) * longint'(kernel_taps[ph * TAPS + j]);
        end
        acc = acc + (longint'(1) << (CFB - 1));
        acc = acc >>> CFB;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end
        if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        return SAMPLE_W'(acc);
    endfunction

    // one accepted input word -> queued resampled words
    function automatic void resample_word(logic signed [SAMPLE_W-1:0] s, bit fin);
        t_u64            filled;
        t_u64            total;
        t_u64            need;
        t_u64            blk;
        int              ph;
        int              made;
        int              last_idx;
        t_resampled_word w;
        if (SOURCE_STEP == TARGET_STEP) begin
            w.sample = s;
            w.eos    = fin;
            add_expected(w);
            return;
        end
        shift_tap(s);
        samples_seen = samples_seen + 1;
        filled = samples_seen;
        total  = fin ? (t_u64'(RT) * samples_seen + RS - 1) / RS : t_u64'(0);
        made   = 0;
        while (made < MAX_RESULTS) begin
            if (fin && outputs_emitted >= total) begin
                break;
            end
            blk  = outputs_emitted / RT;
            ph   = outputs_emitted % RT;
            need = blk * RS + HW + RS;
            if (filled < need) begin
                if (!fin) begin
                    break;
                end
                // past the end: zeros shifted in
                while (filled < need) begin
                    shift_tap('0);
                    filled++;
                end
            end
            w.sample = phase_dot(ph);
            w.eos    = 1'b0;
            add_expected(w);
            outputs_emitted = outputs_emitted + 1;
            made++;
        end
        if (fin) begin
            if (made > 0) begin
                last_idx                 = expected_words.size() - 1;
                w                        = expected_words[last_idx];
                w.eos                    = 1'b1;
                expected_words[last_idx] = w;
            end
            clear_stream_state();
        end
    endfunction

    // ---- sender --------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_W'(SAMPLE_MAX);
            1:       return SAMPLE_W'(SAMPLE_MIN);
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 256)) - 128);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // bursts of random length, random gaps between them (zero gaps too)
    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input bit fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.is_final  <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        resample_word(s, fin);
    endtask

    task automatic park_sender();
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_stream(input int len);
        for (int k = 0; k < len; k++) begin
            send_word(pick_sample(), k == len - 1);
        end
    endtask

    // ---- tests -----------------------------------------------------------------
    // one-word stream: zero history before, zeros flushed after
    task automatic test_lone_sample();
        send_word(SAMPLE_W'(SAMPLE_MAX), 1'b1);
    endtask

    task automatic test_two_samples();
        send_word(SAMPLE_W'(SAMPLE_MIN), 1'b0);
        send_word(SAMPLE_W'(1), 1'b1);
    endtask

    // full-scale steps and alternation drive the overshoot into saturation
    task automatic test_full_scale();
        for (int k = 0; k < 8; k++) begin
            send_word(SAMPLE_W'(SAMPLE_MAX), 1'b0);
        end
        for (int k = 0; k < 8; k++) begin
            send_word(SAMPLE_W'(SAMPLE_MIN), 1'b0);
        end
        for (int k = 0; k < 5; k++) begin
            send_word((k % 2 == 0) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN), 1'b0);
        end
        send_word('0, 1'b1);
    endtask

    task automatic test_random_streams(input int n_words);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 48)
                                              : $urandom_range(1, 24);
            if (len > n_words - sent) begin
                len = n_words - sent;
            end
            send_stream(len);
            sent += len;
        end
    endtask

    // receiver holds off; sender keeps offering until the core stalls its input
    task automatic test_output_hold();
        hold_request = 1'b1;
        send_stream(30);
    endtask

    // sender goes quiet mid-stream until every pending word is out
    task automatic test_drain_pause();
        for (int k = 0; k < 12; k++) begin
            send_word(pick_sample(), 1'b0);
        end
        park_sender();
        wait_drained();
        send_stream(8);
    endtask

    // ---- receiver: own stall pattern plus one long hold ---------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(posedge i_clk);
                end
                hold_request = 1'b0;
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default:   out_ch.ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    // ---- checker ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word sample_out=%0d end_of_stream=%0b",
                         $time, out_ch.sample_out, out_ch.end_of_stream);
                n_errors++;
            end else begin
                oldest_word = expected_words.pop_front();
                if (out_ch.sample_out !== oldest_word.sample) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             $signed(oldest_word.sample), out_ch.sample_out);
                    n_errors++;
                end
                if (out_ch.end_of_stream !== oldest_word.eos) begin
                    $display("%0t: end_of_stream expected %0b actual %0b", $time,
                             oldest_word.eos, out_ch.end_of_stream);
                    n_errors++;
                end
            end
        end
    end

    // ---- watchdog: cycles with no word moving on either side -----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---- sequence --------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        in_ch.is_final  = 1'b0;
        for (int p = 0; p < RT; p++) begin
            for (int j = 0; j < TAPS; j++) begin
                kernel_taps[p * TAPS + j] = kernel_coef(p, j);
            end
        end
        clear_stream_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_sample();
        test_two_samples();
        test_full_scale();
        test_random_streams(150);
        test_output_hold();
        test_drain_pause();
        test_random_streams(95);

        park_sender();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/psr_pkg.sv
hdl/psr_if.sv
hdl/psr_front.sv
hdl/psr_back.sv
hdl/polyphase_sinc_resampler_core.sv
verif/tb.sv
